[rtl/core/hdgc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package hdgc_pkg;
  localparam int CoordBits = 10;
  localparam int FracBits = 4;
  localparam int LenBits = 20;
  localparam int CntBits = 6;
  localparam int RatBits = 16;
  localparam int GesBits = 5;
  localparam int SqBits = 2 * (CoordBits + 1) + 2 * FracBits;
  localparam int RootBits = SqBits / 2 + 1;
  localparam logic [LenBits-1:0] LenMax = '1;
  localparam logic [CntBits-1:0] CntMax = '1;

  typedef struct packed {
    logic [CoordBits-1:0] sx, sy, dx, dy, ex, ey;
    logic                 first, last;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SQRT1, ST_SQRT2, ST_DIV, ST_CLASS, ST_OUT
  } state_t;

  // smallest of three points and a running bound
  function automatic logic [CoordBits-1:0] min3(input logic [CoordBits-1:0] a,
                                                input logic [CoordBits-1:0] b,
                                                input logic [CoordBits-1:0] c,
                                                input logic [CoordBits-1:0] d);
    logic [CoordBits-1:0] m;
    m = d;
    if (a < m) m = a;
    if (b < m) m = b;
    if (c < m) m = c;
    return m;
  endfunction

  // largest of three points and a running bound
  function automatic logic [CoordBits-1:0] max3(input logic [CoordBits-1:0] a,
                                                input logic [CoordBits-1:0] b,
                                                input logic [CoordBits-1:0] c,
                                                input logic [CoordBits-1:0] d);
    logic [CoordBits-1:0] m;
    m = d;
    if (a > m) m = a;
    if (b > m) m = b;
    if (c > m) m = c;
    return m;
  endfunction

  localparam logic [23:0] LenTab [20][2] = '{
    '{24'd1199845, 24'd1326780}, '{24'd1116180, 24'd1258400},
    '{24'd1076780, 24'd1479030}, '{24'd809532, 24'd1236940},
    '{24'd1590680, 24'd1702310}, '{24'd2046080, 24'd2145040},
    '{24'd2707630, 24'd3040320}, '{24'd2267890, 24'd2689330},
    '{24'd2313590, 24'd2839330}, '{24'd2061970, 24'd2958820},
    '{24'd3203630, 24'd3437650}, '{24'd4181190, 24'd4585060},
    '{24'd4031190, 24'd4287600}, '{24'd3704510, 24'd4285150},
    '{24'd4286150, 24'd4885600}, '{24'd5210350, 24'd5849930},
    '{24'd4803390, 24'd5005010}, '{24'd4700110, 24'd5214100},
    '{24'd7307230, 24'd7508270}, '{24'd8000000, 24'd9529360}};

  localparam logic [20:0] RatTab [20][2] = '{
    '{21'd562814, 21'd664894}, '{21'd508197, 21'd577540},
    '{21'd1005680, 21'd1591670}, '{21'd540373, 21'd800000},
    '{21'd1047120, 21'd1111730}, '{21'd467742, 21'd487903},
    '{21'd1125000, 21'd1416670}, '{21'd941463, 21'd1239520},
    '{21'd798387, 21'd862903}, '{21'd580645, 21'd866935},
    '{21'd612903, 21'd802419}, '{21'd700405, 21'd778226},
    '{21'd713710, 21'd834677}, '{21'd979487, 21'd1250000},
    '{21'd1020580, 21'd1092900}, '{21'd923387, 21'd995968},
    '{21'd931707, 21'd975124}, '{21'd931452, 21'd1000000},
    '{21'd899194, 21'd911290}, '{21'd830645, 21'd927419}};
endpackage
`default_nettype wire

[rtl/core/hdgc_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
module hdgc_queue (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  hdgc_pkg::item_t       in_data,
  output logic                  out_valid,
  input  wire                   out_ready,
  output hdgc_pkg::item_t       out_data
);
  hdgc_pkg::item_t mem [2];
  logic wptr, rptr;
  logic [1:0] fill;

  assign in_ready  = fill != 2'd2;
  assign out_valid = fill != 2'd0;
  assign out_data  = mem[rptr];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) mem[wptr] <= in_data;
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= '0;
    end else begin
      if (in_valid && in_ready) wptr <= ~wptr;
      if (out_valid && out_ready) rptr <= ~rptr;
      fill <= fill + {1'b0, in_valid && in_ready} - {1'b0, out_valid && out_ready};
    end
  end
endmodule
`default_nettype wire

[rtl/core/hdgc_core.sv]
`timescale 1ns / 1ps
`default_nettype none
module hdgc_core (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 measure_enable,
  input  wire                                 in_valid,
  output logic                                in_ready,
  input  hdgc_pkg::item_t                     in_data,
  output logic                                out_valid,
  input  wire                                 out_ready,
  output logic [hdgc_pkg::GesBits-1:0]        gesture_code,
  output logic [hdgc_pkg::LenBits-1:0]        total_length,
  output logic [hdgc_pkg::RatBits-1:0]        shape_ratio,
  output logic [hdgc_pkg::CntBits-1:0]        defect_total,
  output logic [hdgc_pkg::CoordBits-1:0]      box_min_x,
  output logic [hdgc_pkg::CoordBits-1:0]      box_min_y,
  output logic [hdgc_pkg::CoordBits-1:0]      box_max_x,
  output logic [hdgc_pkg::CoordBits-1:0]      box_max_y
);
  localparam int CB = hdgc_pkg::CoordBits;
  localparam int SB = hdgc_pkg::SqBits;
  localparam int RB = hdgc_pkg::RootBits;
  localparam int LB = hdgc_pkg::LenBits;
  localparam int SqSteps = SB / 2;
  localparam int DivBits = CB + 12;
  localparam int StepW = $clog2(DivBits + 2);

  hdgc_pkg::state_t state, state_next;
  hdgc_pkg::item_t  it;
  logic [CB-1:0] low_x, low_y, high_x, high_y;
  logic [LB-1:0] length_sum;
  logic [hdgc_pkg::CntBits-1:0] defect_count;
  logic [SB-1:0] rem;
  logic [RB-1:0] root;
  logic [RB+1:0] prem;
  logic [StepW-1:0] step;
  logic [DivBits-1:0] quot;
  logic [CB:0] drem;
  logic [hdgc_pkg::GesBits-1:0] gesture;
  logic [hdgc_pkg::RatBits-1:0] ratio;

  // segment square operands
  logic [CB-1:0] ax, ay, bx, by, adx, ady;
  logic [2*CB:0] sumsq;
  logic [SB-1:0] sq;
  assign ax = (state == hdgc_pkg::ST_SQRT1) ? it.sx : it.dx;
  assign ay = (state == hdgc_pkg::ST_SQRT1) ? it.sy : it.dy;
  assign bx = (state == hdgc_pkg::ST_SQRT1) ? it.dx : it.ex;
  assign by = (state == hdgc_pkg::ST_SQRT1) ? it.dy : it.ey;
  assign adx = (ax > bx) ? ax - bx : bx - ax;
  assign ady = (ay > by) ? ay - by : by - ay;
  assign sumsq = (2*CB+1)'({{CB{1'b0}}, adx} * {{CB{1'b0}}, adx}) +
                 (2*CB+1)'({{CB{1'b0}}, ady} * {{CB{1'b0}}, ady});
  assign sq = SB'({sumsq, {(2 * hdgc_pkg::FracBits){1'b0}}});

  // one restoring root digit per cycle
  logic [SB-1:0] src_rem;
  logic [RB-1:0] root_cur;
  logic [RB+1:0] prem_cur, window, rtest, pnext;
  logic          take;
  assign src_rem  = (step == '0) ? sq : rem;
  assign root_cur = (step == '0) ? '0 : root;
  assign prem_cur = (step == '0) ? '0 : prem;
  assign window = {prem_cur[RB-1:0], src_rem[SB-1 -: 2]};
  assign rtest = {root_cur, 2'b01};
  assign take = window >= rtest;
  assign pnext = take ? window - rtest : window;

  // final rounding and add
  logic [RB-1:0] root_inc;
  logic [LB+1:0] sum_adj;
  assign root_inc = (prem > {2'b00, root}) ? root + RB'(1) : root;
  assign sum_adj = {2'b00, length_sum} + (LB+2)'(root_inc);

  // divider step
  logic [CB+1:0] dtry;
  assign dtry = {drem, quot[DivBits-1]} - {2'b00, high_y};

  // classifier
  function automatic logic in_len(input logic [LB-1:0] len, input int k);
    logic [LB+14-1:0] l;
    logic [24+hdgc_pkg::FracBits-1:0] lo, hi;
    l  = (LB+14)'(len) * (LB+14)'(10000);
    lo = {hdgc_pkg::LenTab[k][0], {hdgc_pkg::FracBits{1'b0}}};
    hi = {hdgc_pkg::LenTab[k][1], {hdgc_pkg::FracBits{1'b0}}};
    return (l > (LB+14)'(lo)) && (l < (LB+14)'(hi));
  endfunction

  function automatic logic [1:0] rcmp(input logic [15:0] r, input logic [20:0] t);
    logic [35:0] a, b;
    a = 36'(r) * 36'd1000000;
    b = {3'b000, t, 12'b0};
    return (a > b) ? 2'd1 : ((a < b) ? 2'd2 : 2'd0);
  endfunction

  function automatic logic [4:0] classify(input logic [LB-1:0] len, input logic [5:0] n,
                                          input logic [15:0] r);
    logic [4:0] g;
    logic [4:0] dflt;
    g = 5'd0;
    dflt = 5'd0;
    case (n)
      6'd1: begin
        if (in_len(len, 0)) begin
          if (in_len(len, 1)) g = (rcmp(r, hdgc_pkg::RatTab[1][1]) == 2'd1) ? 5'd1 : 5'd2;
          else if (in_len(len, 2)) g = (rcmp(r, hdgc_pkg::RatTab[2][0]) != 2'd2) ? 5'd3 : 5'd1;
          else if (in_len(len, 3))
            g = (rcmp(r, hdgc_pkg::RatTab[0][1]) == 2'd1 ||
                 rcmp(r, hdgc_pkg::RatTab[0][0]) == 2'd2) ? 5'd4 : 5'd1;
          else g = 5'd1;
        end else if (in_len(len, 1)) begin
          if (in_len(len, 2)) g = (rcmp(r, hdgc_pkg::RatTab[2][0]) != 2'd2) ? 5'd3 : 5'd2;
          else if (in_len(len, 3)) g = (rcmp(r, hdgc_pkg::RatTab[1][1]) != 2'd2) ? 5'd1 : 5'd4;
          else g = 5'd2;
        end else if (in_len(len, 2)) begin
          if (in_len(len, 3)) g = (rcmp(r, hdgc_pkg::RatTab[2][0]) != 2'd2) ? 5'd3 : 5'd4;
          else g = 5'd3;
        end else if (in_len(len, 3)) g = 5'd4;
      end
      6'd2: begin
        if (in_len(len, 4)) g = 5'd5;
        else if (in_len(len, 5)) begin
          if (in_len(len, 9) && rcmp(r, hdgc_pkg::RatTab[5][1]) == 2'd1) g = 5'd10;
          else g = 5'd6;
        end else if (in_len(len, 6) || in_len(len, 7)) begin
          dflt = in_len(len, 6) ? 5'd7 : 5'd8;
          if (in_len(len, 8) && rcmp(r, hdgc_pkg::RatTab[8][1]) != 2'd1) g = 5'd9;
          else if (in_len(len, 9) && rcmp(r, hdgc_pkg::RatTab[9][1]) != 2'd1) g = 5'd10;
          else g = dflt;
        end else if (in_len(len, 8)) begin
          if (in_len(len, 9) && rcmp(r, hdgc_pkg::RatTab[8][0]) == 2'd2) g = 5'd10;
          else g = 5'd9;
        end else if (in_len(len, 9)) g = 5'd10;
      end
      6'd3: begin
        if (in_len(len, 10)) g = 5'd11;
        else if (in_len(len, 11)) begin
          if (in_len(len, 12) && rcmp(r, hdgc_pkg::RatTab[12][0]) != 2'd2) g = 5'd13;
          else g = 5'd12;
        end else if (in_len(len, 13)) g = 5'd14;
        else if (in_len(len, 14)) g = 5'd15;
      end
      6'd4: begin
        if (in_len(len, 15)) g = 5'd16;
        else if (in_len(len, 16)) begin
          if (in_len(len, 17) && rcmp(r, hdgc_pkg::RatTab[16][1]) == 2'd1) g = 5'd18;
          else g = 5'd17;
        end else if (in_len(len, 17)) g = 5'd18;
      end
      6'd5, 6'd6: begin
        if (n == 6'd5 && in_len(len, 18)) g = 5'd19;
        else if (in_len(len, 19)) g = 5'd20;
      end
      default: g = 5'd0;
    endcase
    return g;
  endfunction

  assign in_ready = (state == hdgc_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= hdgc_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      hdgc_pkg::ST_IDLE:
        if (in_valid) begin
          if (measure_enable) state_next = hdgc_pkg::ST_SQRT1;
          else state_next = in_data.last ? hdgc_pkg::ST_DIV : hdgc_pkg::ST_IDLE;
        end
      hdgc_pkg::ST_SQRT1, hdgc_pkg::ST_SQRT2: begin
        if (step == StepW'(SqSteps)) begin
          if (state == hdgc_pkg::ST_SQRT1) state_next = hdgc_pkg::ST_SQRT2;
          else state_next = it.last ? hdgc_pkg::ST_DIV : hdgc_pkg::ST_IDLE;
        end
      end
      hdgc_pkg::ST_DIV:
        if (step == StepW'(DivBits + 1)) state_next = hdgc_pkg::ST_CLASS;
      hdgc_pkg::ST_CLASS: state_next = hdgc_pkg::ST_OUT;
      hdgc_pkg::ST_OUT:
        if (out_ready) state_next = hdgc_pkg::ST_IDLE;
      default: state_next = hdgc_pkg::ST_IDLE;
    endcase
  end

  assign out_valid = (state == hdgc_pkg::ST_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      low_x <= '1; low_y <= '1; high_x <= '0; high_y <= '0;
      length_sum <= '0; defect_count <= '0; step <= '0;
    end else begin
      case (state)
        hdgc_pkg::ST_IDLE: begin
          step <= '0;
          if (in_valid) begin
            it <= in_data;
            if (in_data.first) begin
              low_x <= hdgc_pkg::min3(in_data.sx, in_data.dx, in_data.ex, '1);
              low_y <= hdgc_pkg::min3(in_data.sy, in_data.dy, in_data.ey, '1);
              high_x <= hdgc_pkg::max3(in_data.sx, in_data.dx, in_data.ex, '0);
              high_y <= hdgc_pkg::max3(in_data.sy, in_data.dy, in_data.ey, '0);
              length_sum <= '0;
              defect_count <= 6'd1;
            end else begin
              low_x <= hdgc_pkg::min3(in_data.sx, in_data.dx, in_data.ex, low_x);
              low_y <= hdgc_pkg::min3(in_data.sy, in_data.dy, in_data.ey, low_y);
              high_x <= hdgc_pkg::max3(in_data.sx, in_data.dx, in_data.ex, high_x);
              high_y <= hdgc_pkg::max3(in_data.sy, in_data.dy, in_data.ey, high_y);
              if (defect_count != hdgc_pkg::CntMax) defect_count <= defect_count + 6'd1;
            end
          end
        end
        hdgc_pkg::ST_SQRT1, hdgc_pkg::ST_SQRT2: begin
          if (step == StepW'(SqSteps)) begin
            length_sum <= sum_adj[LB+1:LB] != 2'b00 ? hdgc_pkg::LenMax : sum_adj[LB-1:0];
            step <= '0;
          end else begin
            step <= step + StepW'(1);
            rem <= {src_rem[SB-3:0], 2'b00};
            prem <= pnext;
            root <= {root_cur[RB-2:0], take};
          end
        end
        hdgc_pkg::ST_DIV: begin
          if (step == '0) begin
            quot <= {high_x, 12'b0};
            drem <= '0;
            step <= step + StepW'(1);
          end else if (step != StepW'(DivBits + 1)) begin
            step <= step + StepW'(1);
            if (!dtry[CB+1]) begin
              drem <= dtry[CB:0];
              quot <= {quot[DivBits-2:0], 1'b1};
            end else begin
              drem <= {drem[CB-1:0], quot[DivBits-1]};
              quot <= {quot[DivBits-2:0], 1'b0};
            end
          end else begin
            if (high_y == '0 || quot[DivBits-1:16] != '0) ratio <= '1;
            else ratio <= quot[15:0];
          end
        end
        hdgc_pkg::ST_CLASS:
          gesture <= measure_enable ? classify(length_sum, defect_count, ratio) : '0;
        default: ;
      endcase
    end
  end

  assign gesture_code = gesture;
  assign total_length = length_sum;
  assign shape_ratio  = ratio;
  assign defect_total = defect_count;
  assign box_min_x = low_x;
  assign box_min_y = low_y;
  assign box_max_x = high_x;
  assign box_max_y = high_y;
endmodule
`default_nettype wire

[rtl/core/hand_defect_gesture_classifier.sv]
// channel  | valid            | ready            | beat
// in       | in_valid         | in_ready         | one defect
// cfg      | cfg_valid        | cfg_ready        | measure_enable
// out      | out_valid        | out_ready        | one frame result
// a defect is written into the queue, then taken by the back end, which handles it
// in its idle state with measuring off; with it on, two square roots follow, one
// digit a cycle plus a rounding add each; the last defect adds the divider steps,
// a classify state and the result beat, held until out_ready
// reset clears the box, sum, count and register; a two-entry queue holds
// defects while the back end works or the result waits
`timescale 1ns / 1ps
`default_nettype none
module hand_defect_gesture_classifier (
  input  wire        clk,
  input  wire        rst,
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire        cfg_data,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire  [9:0] start_x,
  input  wire  [9:0] start_y,
  input  wire  [9:0] deep_x,
  input  wire  [9:0] deep_y,
  input  wire  [9:0] end_x,
  input  wire  [9:0] end_y,
  input  wire        first_defect,
  input  wire        last_defect,
  output logic       out_valid,
  input  wire        out_ready,
  output logic [4:0] gesture_code,
  output logic [19:0] total_length,
  output logic [15:0] shape_ratio,
  output logic [5:0] defect_total,
  output logic [9:0] box_min_x,
  output logic [9:0] box_min_y,
  output logic [9:0] box_max_x,
  output logic [9:0] box_max_y
);
  logic measure_enable;
  hdgc_pkg::item_t in_item, q_item;
  logic q_valid, q_ready;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) measure_enable <= 1'b0;
    else if (cfg_valid) measure_enable <= cfg_data;
  end

  assign in_item = '{sx: start_x, sy: start_y, dx: deep_x, dy: deep_y, ex: end_x, ey: end_y,
                     first: first_defect, last: last_defect};

  hdgc_queue u_queue (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_item),
    .out_valid(q_valid), .out_ready(q_ready), .out_data(q_item)
  );

  hdgc_core u_core (
    .clk(clk), .rst(rst), .measure_enable(measure_enable),
    .in_valid(q_valid), .in_ready(q_ready), .in_data(q_item),
    .out_valid(out_valid), .out_ready(out_ready),
    .gesture_code(gesture_code), .total_length(total_length), .shape_ratio(shape_ratio),
    .defect_total(defect_total), .box_min_x(box_min_x), .box_min_y(box_min_y),
    .box_max_x(box_max_x), .box_max_y(box_max_y)
  );
endmodule
`default_nettype wire
